[rtl/multilevel_priority_ready_queue_assert.svh]
// Assertion macros shared by the ready queue RTL.
`ifndef MULTILEVEL_PRIORITY_READY_QUEUE_ASSERT_SVH
`define MULTILEVEL_PRIORITY_READY_QUEUE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define MLPQ_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MLPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MLPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mlpq_pkg.sv]
// Shared widths, codes and types of the multilevel priority ready queue.
`timescale 1ns / 1ps
package mlpq_pkg;

   // Field widths of the request and response words
   localparam int CMD_W     = 1;
   localparam int TASK_ID_W = 8;
   localparam int PRIO_W    = 4;
   localparam int STATUS_W  = 2;
   localparam int TOTAL_W   = 7;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Commands
   localparam cmd_type CMD_PUSH = 1'b0;
   localparam cmd_type CMD_POP  = 1'b1;

   // Response status codes
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_POOL_FULL = 2'd1;
   localparam status_type ST_EMPTY     = 2'd2;
   localparam status_type ST_BAD_PRIO  = 2'd3;

endpackage

[rtl/mlpq_if.sv]
// Request and response channel interfaces of the ready queue.
`timescale 1ns / 1ps

// Request word: push or pop command
interface mlpq_req_if;
   logic                            valid;
   logic                            ready;
   mlpq_pkg::cmd_type               command;
   logic [mlpq_pkg::TASK_ID_W-1:0]  task_id;
   logic [mlpq_pkg::PRIO_W-1:0]     priority_req;

   modport source (output valid, command, task_id, priority_req, input ready);
   modport sink   (input valid, command, task_id, priority_req, output ready);
endinterface

// Response word: one per request
interface mlpq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mlpq_pkg::TASK_ID_W-1:0]  popped_task;
   mlpq_pkg::status_type            status;
   logic                            queue_empty;
   logic [mlpq_pkg::TOTAL_W-1:0]    total_entries;

   modport source (output valid, popped_task, status, queue_empty, total_entries,
                   input ready);
   modport sink   (input valid, popped_task, status, queue_empty, total_entries,
                   output ready);
endinterface

[rtl/mlpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mlpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port; read returns old data on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/multilevel_priority_ready_queue.sv]
// Multilevel priority ready queue: one FIFO per level over a shared node pool.
//
// Usage:
//  - req_ch carries push (task_id at priority_req) and pop commands; rsp_ch
//    returns exactly one word per request, in order: popped task, status
//    (ok, pool full, queue empty, bad priority), empty flag and total count.
//  - A pop serves the head of the highest non-empty level; errors change nothing.
//  - A request is registered in the input register on acceptance; its response
//    is registered in the response register when the request stage advances.
//  - One request per cycle is sustained while rsp_ch does not stall. The
//    next queue head, its successor and the top of the free-node stack are read
//    from the node RAMs ahead of use, with forwarding of writes from the cycle before.
//  - When rsp_ch stalls, the held response keeps the request stage from
//    advancing; one more request is taken into the input register, then
//    req_ch.ready drops until the response is taken.
//  - Reset (synchronous) empties all levels and fills the free pool at once;
//    untouched free-stack entries read back as their own index, so no
//    clearing pass is needed. Requests are taken in the cycle after reset.
`timescale 1ns / 1ps
`include "multilevel_priority_ready_queue_assert.svh"
module multilevel_priority_ready_queue #(
   parameter int NODES     = 64,
   parameter int LEVELS    = 8,
   parameter int TASK_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   mlpq_req_if.sink    req_ch,
   mlpq_rsp_if.source  rsp_ch
);
   localparam int NB = $clog2(NODES);
   localparam int CB = $clog2(NODES + 1);
   localparam int LB = $clog2(LEVELS);
   localparam int TW = mlpq_pkg::TASK_ID_W;
   localparam int PW = mlpq_pkg::PRIO_W;
   localparam int OW = mlpq_pkg::TOTAL_W;

   // Input register
   logic                 in_valid_ff;
   mlpq_pkg::cmd_type    in_cmd_ff;
   logic [TW-1:0]        in_task_ff;
   logic [PW-1:0]        in_prio_ff;

   // Response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]        rsp_task_ff, rsp_task_in;
   mlpq_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic [OW-1:0]        rsp_total_ff, rsp_total_in;

   // Queue state
   logic [CB-1:0] cnt_ff [LEVELS];
   logic [CB-1:0] cnt_in [LEVELS];
   logic [NB-1:0] head_ff [LEVELS];
   logic [NB-1:0] head_in [LEVELS];
   logic [NB-1:0] tail_ff [LEVELS];
   logic [NB-1:0] tail_in [LEVELS];
   logic [CB-1:0] fc_ff, fc_in;
   logic [CB-1:0] tot_ff, tot_in;
   logic [CB-1:0] lw_ff, lw_in;

   // Lookahead of the top level head and the free-stack top
   logic [LB-1:0]        pf_lv_ff, pf_lv_in;
   logic [NB-1:0]        pf_head_ff, pf_head_in;
   logic [NB-1:0]        fs_addr_ff, fs_addr_in;
   logic                 fs_ident_ff, fs_ident_in;
   logic                 fs_fwd_ff, fs_fwd_in;
   logic [NB-1:0]        fs_fwd_data_ff;
   logic                 nt_fwd_ff, nt_fwd_in;
   logic [TASK_BITS-1:0] nt_fwd_data_ff;
   logic                 nn_fwd_ff, nn_fwd_in;
   logic [NB-1:0]        nn_fwd_data_ff;

   // RAM ports
   logic [TASK_BITS-1:0] nt_rd_data, nt_wr_data;
   logic                 nt_we;
   logic [NB-1:0]        nn_rd_data, nn_wr_addr;
   logic                 nn_we;
   logic [NB-1:0]        fs_rd_data;
   logic                 fs_we;

   // Step control
   logic                  advance, step, is_push, prio_ok, pool_empty, any_queued;
   logic                  push_do, pop_do;
   logic [LB-1:0]         prio_idx;
   logic [NB-1:0]         free_top, head_next;
   logic [TASK_BITS-1:0]  head_task;
   logic [TASK_BITS+TW-1:0] task_ext, pop_ext;
   logic [CB+OW-1:0]      tot_ext;
   logic [CB-1:0]         fc_dec;
   logic [LEVELS-1:0]     level_busy;

   // Handshake
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   // Decode of the held request
   assign is_push    = (in_cmd_ff == mlpq_pkg::CMD_PUSH);
   assign prio_ok    = {1'b0, in_prio_ff} < (PW + 1)'(LEVELS);
   assign prio_idx   = in_prio_ff[LB-1:0];
   assign pool_empty = (fc_ff == '0);
   assign any_queued = (tot_ff != '0);
   assign push_do    = step && is_push && prio_ok && !pool_empty;
   assign pop_do     = step && !is_push && any_queued;

   // Lookahead data with forwarding
   assign free_top  = fs_ident_ff ? fs_addr_ff : (fs_fwd_ff ? fs_fwd_data_ff : fs_rd_data);
   assign head_task = nt_fwd_ff ? nt_fwd_data_ff : nt_rd_data;
   assign head_next = nn_fwd_ff ? nn_fwd_data_ff : nn_rd_data;

   // Task width adaption on store and on read-out
   assign task_ext   = {{TASK_BITS{1'b0}}, in_task_ff};
   assign nt_wr_data = task_ext[TASK_BITS-1:0];
   assign pop_ext    = {{TW{1'b0}}, head_task};

   // Node RAM writes
   assign nt_we      = push_do;
   assign nn_we      = push_do && (cnt_ff[prio_idx] != '0);
   assign nn_wr_addr = tail_ff[prio_idx];
   assign fs_we      = pop_do;

   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         level_busy[i] = (cnt_ff[i] != '0);
      end
   end

   // Next queue state
   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      fc_in   = fc_ff;
      tot_in  = tot_ff;
      if (push_do) begin
         if (cnt_ff[prio_idx] != '0) begin
            tail_in[prio_idx] = free_top;
         end else begin
            head_in[prio_idx] = free_top;
            tail_in[prio_idx] = free_top;
         end
         cnt_in[prio_idx] = cnt_ff[prio_idx] + 1'b1;
         fc_in  = fc_ff - 1'b1;
         tot_in = tot_ff + 1'b1;
      end else if (pop_do) begin
         if (cnt_ff[pf_lv_ff] > CB'(1)) begin
            head_in[pf_lv_ff] = head_next;
         end
         cnt_in[pf_lv_ff] = cnt_ff[pf_lv_ff] - 1'b1;
         fc_in  = fc_ff + 1'b1;
         tot_in = tot_ff - 1'b1;
      end
      lw_in = (fc_in < lw_ff) ? fc_in : lw_ff;
   end

   // Top level of the next state and its head node
   always_comb begin
      pf_lv_in = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (cnt_in[i] != '0) begin
            pf_lv_in = LB'(i);
         end
      end
      pf_head_in = head_in[pf_lv_in];
      nt_fwd_in  = push_do && (free_top == pf_head_in);
      nn_fwd_in  = nn_we && (nn_wr_addr == pf_head_in);
   end

   // Free-stack top of the next state
   always_comb begin
      fc_dec      = fc_in - 1'b1;
      fs_addr_in  = fc_dec[NB-1:0];
      fs_ident_in = (fc_dec < lw_in);
      fs_fwd_in   = pop_do;
   end

   // Response word
   always_comb begin
      tot_ext       = {{OW{1'b0}}, tot_in};
      rsp_task_in   = '0;
      rsp_status_in = mlpq_pkg::ST_OK;
      if (is_push) begin
         if (!prio_ok) begin
            rsp_status_in = mlpq_pkg::ST_BAD_PRIO;
         end else if (pool_empty) begin
            rsp_status_in = mlpq_pkg::ST_POOL_FULL;
         end
      end else if (!any_queued) begin
         rsp_status_in = mlpq_pkg::ST_EMPTY;
      end else begin
         rsp_task_in = pop_ext[TW-1:0];
      end
      rsp_empty_in = (tot_in == '0);
      rsp_total_in = tot_ext[OW-1:0];
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            cnt_ff[i] <= '0;
         end
         fc_ff       <= CB'(NODES);
         tot_ff      <= '0;
         lw_ff       <= CB'(NODES);
         pf_lv_ff    <= '0;
         fs_addr_ff  <= NB'(NODES - 1);
         fs_ident_ff <= 1'b1;
         fs_fwd_ff   <= 1'b0;
         nt_fwd_ff   <= 1'b0;
         nn_fwd_ff   <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         fc_ff        <= fc_in;
         tot_ff       <= tot_in;
         lw_ff        <= lw_in;
         pf_lv_ff     <= pf_lv_in;
         fs_addr_ff   <= fs_addr_in;
         fs_ident_ff  <= fs_ident_in;
         fs_fwd_ff    <= fs_fwd_in;
         nt_fwd_ff    <= nt_fwd_in;
         nn_fwd_ff    <= nn_fwd_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_cmd_ff  <= req_ch.command;
         in_task_ff <= req_ch.task_id;
         in_prio_ff <= req_ch.priority_req;
      end
      if (step) begin
         rsp_task_ff   <= rsp_task_in;
         rsp_status_ff <= rsp_status_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_total_ff  <= rsp_total_in;
      end
      head_ff        <= head_in;
      tail_ff        <= tail_in;
      pf_head_ff     <= pf_head_in;
      fs_fwd_data_ff <= pf_head_ff;
      nt_fwd_data_ff <= nt_wr_data;
      nn_fwd_data_ff <= free_top;
   end

   // Task of each node
   mlpq_ram #(.WIDTH(TASK_BITS), .DEPTH(NODES)) u_node_task (
      .clock   (clock),
      .wr_en   (nt_we),
      .wr_addr (free_top),
      .wr_data (nt_wr_data),
      .rd_addr (pf_head_in),
      .rd_data (nt_rd_data)
   );

   // Successor of each node within its level
   mlpq_ram #(.WIDTH(NB), .DEPTH(NODES)) u_node_next (
      .clock   (clock),
      .wr_en   (nn_we),
      .wr_addr (nn_wr_addr),
      .wr_data (free_top),
      .rd_addr (pf_head_in),
      .rd_data (nn_rd_data)
   );

   // Free-node stack
   mlpq_ram #(.WIDTH(NB), .DEPTH(NODES)) u_free_stack (
      .clock   (clock),
      .wr_en   (fs_we),
      .wr_addr (fc_ff[NB-1:0]),
      .wr_data (pf_head_ff),
      .rd_addr (fs_addr_in),
      .rd_data (fs_rd_data)
   );

   // Response outputs
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.popped_task   = rsp_task_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.queue_empty   = rsp_empty_ff;
   assign rsp_ch.total_entries = rsp_total_ff;

   // Checks
   `MLPQ_ASSERT_ALWAYS(a_pool_conserved,
      ({1'b0, fc_ff} + {1'b0, tot_ff}) == (CB + 1)'(NODES), "free plus queued differs from pool size")
   `MLPQ_ASSERT_ALWAYS(a_total_matches_levels,
      (tot_ff == '0) == (level_busy == '0), "total count disagrees with level counts")
   `MLPQ_ASSERT_ALWAYS(a_low_water, lw_ff <= fc_ff, "free-stack low water above free count")
   `MLPQ_ASSERT_NEXT(a_pop_decrements, pop_do, (tot_ff + 1'b1) == $past(tot_ff),
      "pop did not decrement total")
   `MLPQ_ASSERT_NEXT(a_stall_holds_state, rsp_ch.valid && !rsp_ch.ready, $stable(tot_ff),
      "queue state moved while response stalled")
endmodule

[tb/tb.sv]
// Self-checking testbench for the multilevel priority ready queue.
`timescale 1ns / 1ps
module tb;

   localparam int NODES     = 64;
   localparam int LEVELS    = 8;
   localparam int TASK_BITS = 8;

   // One response word as the queue should return it
   typedef struct packed {
      logic [mlpq_pkg::TASK_ID_W-1:0] popped;
      mlpq_pkg::status_type           status;
      logic                           empty;
      logic [mlpq_pkg::TOTAL_W-1:0]   total;
   } rsp_word_type;

   // Behavioral queue model plus the list of responses still to come
   class ready_queue_checker #(int LVLS = 8, int POOL = 64);
      logic [mlpq_pkg::TASK_ID_W-1:0] level_fifo[LVLS][$];
      int unsigned                    queued;
      rsp_word_type                   pending_rsp[$];
      int unsigned                    errors;
      int unsigned                    mismatches;

      // Apply one accepted request to the model and queue its response
      function void note_request(mlpq_pkg::cmd_type cmd,
                                 logic [mlpq_pkg::TASK_ID_W-1:0] tid,
                                 logic [mlpq_pkg::PRIO_W-1:0] prio);
         rsp_word_type r;
         int           lv;
         r.popped = '0;
         r.status = mlpq_pkg::ST_OK;
         lv = -1;
         if (cmd == mlpq_pkg::CMD_PUSH) begin
            if (prio >= LVLS) begin
               r.status = mlpq_pkg::ST_BAD_PRIO;
            end else if (queued >= POOL) begin
               r.status = mlpq_pkg::ST_POOL_FULL;
            end else begin
               level_fifo[prio].push_back(
                  mlpq_pkg::TASK_ID_W'(tid & ((1 << TASK_BITS) - 1)));
               queued++;
            end
         end else begin
            // highest non-empty level is served
            for (int i = LVLS - 1; i >= 0; i--) begin
               if (lv < 0 && level_fifo[i].size() != 0) lv = i;
            end
            if (lv < 0) begin
               r.status = mlpq_pkg::ST_EMPTY;
            end else begin
               r.popped = level_fifo[lv].pop_front();
               queued--;
            end
         end
         r.empty = (queued == 0);
         r.total = queued[mlpq_pkg::TOTAL_W-1:0];
         pending_rsp.push_back(r);
      endfunction

      // Compare one accepted response with the oldest pending one
      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (pending_rsp.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: popped=%0d status=%0d empty=%0d total=%0d",
                        got.popped, got.status, got.empty, got.total);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.popped !== want.popped || got.status !== want.status ||
             got.empty !== want.empty || got.total !== want.total) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected popped=%0d status=%0d empty=%0d total=%0d,",
                         " got popped=%0d status=%0d empty=%0d total=%0d"},
                        want.popped, want.status, want.empty, want.total,
                        got.popped, got.status, got.empty, got.total);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   mlpq_req_if req_ch ();
   mlpq_rsp_if rsp_ch ();

   multilevel_priority_ready_queue #(
      .NODES(NODES),
      .LEVELS(LEVELS),
      .TASK_BITS(TASK_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   ready_queue_checker #(LEVELS, NODES) sb;

   int sender_idle_pct;
   int sink_stall_pct;
   int sink_hold;

   // Clock, 10 ns period
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Response side: random stalls, optional long hold-off, check each word
   initial begin
      forever begin
         rsp_ch.ready <= (sink_hold > 0) ? 1'b0 : ($urandom_range(99) >= sink_stall_pct);
         if (sink_hold > 0) sink_hold--;
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_response('{rsp_ch.popped_task, rsp_ch.status,
                                rsp_ch.queue_empty, rsp_ch.total_entries});
      end
   end

   // Offer one request word, with random idle cycles first
   task automatic send_word(mlpq_pkg::cmd_type cmd,
                            logic [mlpq_pkg::TASK_ID_W-1:0] tid,
                            logic [mlpq_pkg::PRIO_W-1:0] prio);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= cmd;
      req_ch.task_id      <= tid;
      req_ch.priority_req <= prio;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(cmd, tid, prio);
   endtask

   // Push with a mostly legal priority
   task automatic push_random();
      logic [mlpq_pkg::PRIO_W-1:0] prio;
      prio = ($urandom_range(9) == 0) ? mlpq_pkg::PRIO_W'($urandom_range(15, LEVELS))
                                      : mlpq_pkg::PRIO_W'($urandom_range(LEVELS - 1));
      send_word(mlpq_pkg::CMD_PUSH, mlpq_pkg::TASK_ID_W'($urandom_range(255)), prio);
   endtask

   // Pop with junk in the ignored fields
   task automatic pop_random();
      send_word(mlpq_pkg::CMD_POP, mlpq_pkg::TASK_ID_W'($urandom_range(255)),
                mlpq_pkg::PRIO_W'($urandom_range(15)));
   endtask

   task automatic mixed_run(int n, int push_pct);
      repeat (n) begin
         if ($urandom_range(99) < push_pct) push_random();
         else pop_random();
      end
   endtask

   // Fill the pool past full, then drain past empty
   task automatic fill_and_drain();
      while (sb.queued < NODES) push_random();
      send_word(mlpq_pkg::CMD_PUSH, mlpq_pkg::TASK_ID_W'($urandom_range(255)),
                mlpq_pkg::PRIO_W'($urandom_range(15, LEVELS)));
      push_random();
      send_word(mlpq_pkg::CMD_PUSH, mlpq_pkg::TASK_ID_W'($urandom_range(255)),
                mlpq_pkg::PRIO_W'($urandom_range(LEVELS - 1)));
      while (sb.queued > 0) pop_random();
      pop_random();
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Main sequence
   initial begin
      int idle_tab[4];
      int stall_tab[4];
      idle_tab  = '{0, 74, 0, 25};
      stall_tab = '{0, 0, 74, 25};
      sb = new;
      sender_idle_pct = 0;
      sink_stall_pct  = 0;
      sink_hold       = 0;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.command      <= mlpq_pkg::CMD_PUSH;
      req_ch.task_id      <= '0;
      req_ch.priority_req <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pop, field extremes, bad priorities, level order, FIFO order
      send_word(mlpq_pkg::CMD_POP, 8'h00, 4'h0);
      send_word(mlpq_pkg::CMD_PUSH, 8'h00, 4'h0);
      send_word(mlpq_pkg::CMD_PUSH, 8'hFF, 4'(LEVELS - 1));
      send_word(mlpq_pkg::CMD_PUSH, 8'hAA, 4'(LEVELS));
      send_word(mlpq_pkg::CMD_PUSH, 8'h55, 4'hF);
      send_word(mlpq_pkg::CMD_PUSH, 8'h5A, 4'h3);
      send_word(mlpq_pkg::CMD_PUSH, 8'hA5, 4'(LEVELS - 1));
      send_word(mlpq_pkg::CMD_POP, 8'h00, 4'h0);
      send_word(mlpq_pkg::CMD_POP, 8'h00, 4'h0);
      send_word(mlpq_pkg::CMD_POP, 8'h00, 4'h0);
      send_word(mlpq_pkg::CMD_POP, 8'h00, 4'h0);
      send_word(mlpq_pkg::CMD_POP, 8'hFF, 4'hF);
      send_word(mlpq_pkg::CMD_PUSH, 8'h11, 4'h2);
      send_word(mlpq_pkg::CMD_PUSH, 8'h22, 4'h2);
      send_word(mlpq_pkg::CMD_PUSH, 8'h33, 4'h2);
      send_word(mlpq_pkg::CMD_POP, 8'h00, 4'h0);
      send_word(mlpq_pkg::CMD_PUSH, 8'h44, 4'h6);
      send_word(mlpq_pkg::CMD_POP, 8'h00, 4'h0);
      send_word(mlpq_pkg::CMD_POP, 8'h00, 4'h0);
      send_word(mlpq_pkg::CMD_POP, 8'h00, 4'h0);
      send_word(mlpq_pkg::CMD_POP, 8'h00, 4'h0);
      wait_drained();

      // Random phases with different idle and stall rates
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct = idle_tab[ph];
         sink_stall_pct  = stall_tab[ph];
         if (ph == 0) begin
            // long hold-off on the response side while requests keep coming
            sink_hold = 60;
            repeat (30) push_random();
            wait_drained();
         end
         fill_and_drain();
         mixed_run(60, 70);
         mixed_run(60, 50);
         mixed_run(60, 30);
         mixed_run(60, 55);
         wait_drained();
      end

      // Let any stray response show up
      repeat (10) @(posedge clock);
      if (sb.pending_rsp.size() != 0) sb.errors++;
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
